// ----- sv/kps_pkg.sv -----
package kps_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int NUM_VALS       = 7;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int FACTOR_W       = 16;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLAYING     = 3'd0,
        CFG_TICK_RATE   = 3'd1,
        CFG_LOOP_LENGTH = 3'd2,
        CFG_FRAME_COUNT = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic        playing;
        logic [31:0] tick_rate;
        logic [31:0] loop_length;
        logic [4:0]  frame_count;
    } t_cfg;

    typedef struct packed {
        logic [31:0]                key_time;
        logic [NUM_VALS-1:0][31:0]  vals;
    } t_entry;

    typedef struct packed {
        logic        is_tick;
        logic [3:0]  key_index;
        t_entry      entry;
        logic [23:0] delta;
    } t_item;

    typedef struct packed {
        logic [NUM_VALS-1:0][31:0] vals;
        logic [31:0]               anim_time;
    } t_pose;

endpackage

// ----- sv/kps_front.sv -----
module kps_front #(
    parameter int MAX_FRAMES = kps_pkg::MAX_FRAMES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  kps_pkg::t_item i_item,
    output logic          o_push,
    input  logic          i_push_ready,
    output kps_pkg::t_item o_item
);
    import kps_pkg::*;

    logic  r_valid;
    logic  r_keep;
    t_item r_item;

    // A load aimed beyond the table is dropped here and never queued.
    assign o_push  = r_valid && r_keep;
    assign o_ready = !r_valid || !r_keep || i_push_ready;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
            r_keep <= (i_item.is_tick == REQ_TICK) || (32'(i_item.key_index) < MAX_FRAMES);
        end
    end

endmodule

// ----- sv/kps_queue.sv -----
module kps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_push_ready,
    input  kps_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_pop,
    output kps_pkg::t_item o_item
);
    import kps_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_mem [QUEUE_DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_push_ready = r_count != CW'(QUEUE_DEPTH);
    assign o_valid      = r_count != '0;
    assign o_item       = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (32'(r_wp) == QUEUE_DEPTH - 1) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (32'(r_rp) == QUEUE_DEPTH - 1) ? '0 : r_rp + PW'(1);
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= QUEUE_DEPTH)
        else $error("queue occupancy exceeds its depth");
`endif

endmodule

// ----- sv/kps_back.sv -----
module kps_back #(
    parameter int MAX_FRAMES = kps_pkg::MAX_FRAMES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  kps_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_pop,
    input  kps_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output kps_pkg::t_pose o_pose
);
    import kps_pkg::*;

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW = $clog2(MAX_FRAMES + 1);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_ADV  = 9'b000000010,
        S_MOD  = 9'b000000100,
        S_SRD  = 9'b000001000,
        S_SCMP = 9'b000010000,
        S_DIV  = 9'b000100000,
        S_LMUL = 9'b001000000,
        S_LADD = 9'b010000000,
        S_EMIT = 9'b100000000
    } t_state;

    t_state                    r_state;
    t_entry                    r_mem [MAX_FRAMES];
    t_entry                    r_q;
    t_entry                    r_prev;
    t_entry                    r_a;
    t_entry                    r_b;
    logic [IW-1:0]             r_idx;
    logic [55:0]               r_prod;
    logic [31:0]               r_ph;
    logic [31:0]               r_num;
    logic [32:0]               r_rem;
    logic [31:0]               r_span;
    logic [4:0]                r_cnt;
    logic [FACTOR_W-1:0]       r_fac;
    logic [2:0]                r_j;
    logic signed [49:0]        r_mp;
    logic [NUM_VALS-1:0][31:0] r_res;
    logic                      r_ovalid;
    t_pose                     r_pose;

    logic [NW-1:0]             n_frames;
    logic [40:0]               sum;
    logic [31:0]               sat;
    logic [32:0]               mod_t;
    logic [32:0]               div_t;
    logic signed [32:0]        diff;
    logic signed [33:0]        lerp;
    logic                      mem_we;
    logic [IW-1:0]             wa;
    logic                      hit;
    logic                      last;

    assign n_frames = (32'(i_cfg.frame_count) > MAX_FRAMES) ? NW'(MAX_FRAMES)
                                                            : NW'(i_cfg.frame_count);
    assign sum   = {9'd0, r_ph} + {1'b0, r_prod[55:16]};
    assign sat   = (sum[40:32] != '0) ? 32'hFFFF_FFFF : sum[31:0];
    assign mod_t = {r_rem[31:0], r_num[31]};
    assign div_t = {r_rem[31:0], 1'b0};
    assign diff  = $signed({r_b.vals[r_j][31], r_b.vals[r_j]})
                 - $signed({r_a.vals[r_j][31], r_a.vals[r_j]});
    assign lerp  = $signed({{2{r_a.vals[r_j][31]}}, r_a.vals[r_j]}) + r_mp[49:16];
    assign o_pop  = (r_state == S_IDLE) && i_valid;
    assign mem_we = o_pop && (i_item.is_tick == REQ_LOAD);
    assign wa     = IW'(i_item.key_index);
    assign hit    = (r_idx != '0) && (r_prev.key_time <= r_ph) && (r_ph < r_q.key_time);
    assign last   = (NW'(r_idx) + NW'(1)) == n_frames;
    assign o_valid = r_ovalid;
    assign o_pose  = r_pose;

    // The table has one write port for loads and one registered read port for the search.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wa] <= i_item.entry;
        end
        r_q <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_ph     <= '0;
        end else begin
            // The emit step handles its own output register.
            if (r_ovalid && i_ready && (r_state != S_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_item.is_tick == REQ_TICK) && i_cfg.playing) begin
                        r_prod  <= 56'(i_item.delta) * 56'(i_cfg.tick_rate);
                        r_state <= S_ADV;
                    end
                end
                S_ADV: begin
                    r_idx <= '0;
                    if ((i_cfg.loop_length != '0) && (sat > i_cfg.loop_length)) begin
                        r_num   <= sat;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_MOD;
                    end else begin
                        r_ph    <= sat;
                        r_state <= (n_frames < NW'(2)) ? S_IDLE : S_SRD;
                    end
                end
                S_MOD: begin
                    r_num <= {r_num[30:0], 1'b0};
                    r_rem <= (mod_t >= {1'b0, i_cfg.loop_length})
                           ? mod_t - {1'b0, i_cfg.loop_length} : mod_t;
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_ph    <= (mod_t >= {1'b0, i_cfg.loop_length})
                                 ? 32'(mod_t - {1'b0, i_cfg.loop_length}) : mod_t[31:0];
                        r_state <= (n_frames < NW'(2)) ? S_IDLE : S_SRD;
                    end
                end
                S_SRD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    if (hit) begin
                        r_a     <= r_prev;
                        r_b     <= r_q;
                        r_rem   <= {1'b0, r_ph - r_prev.key_time};
                        r_span  <= r_q.key_time - r_prev.key_time;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_prev <= r_q;
                        if (last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_SRD;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= (div_t >= {1'b0, r_span}) ? div_t - {1'b0, r_span} : div_t;
                    r_fac <= {r_fac[FACTOR_W-2:0], div_t >= {1'b0, r_span}};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(FACTOR_W - 1)) begin
                        r_j     <= '0;
                        r_state <= S_LMUL;
                    end
                end
                S_LMUL: begin
                    r_mp    <= 50'(diff * $signed({1'b0, r_fac}));
                    r_state <= S_LADD;
                end
                S_LADD: begin
                    r_res[r_j] <= lerp[31:0];
                    if (r_j == 3'(NUM_VALS - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_j     <= r_j + 3'd1;
                        r_state <= S_LMUL;
                    end
                end
                S_EMIT: begin
                    if (!r_ovalid || i_ready) begin
                        r_pose.vals      <= r_res;
                        r_pose.anim_time <= r_ph;
                        r_ovalid         <= 1'b1;
                        r_state          <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_EMIT))
        else $error("result word raised outside the emit step");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_span}))
        else $error("divider remainder not below the interval span");
`endif

endmodule

// ----- sv/keyframe_pose_sampler.sv -----
// Keyframe pose sampler: linear interpolation between keyframes in Q16.16.
// Input channel (i_in_valid / o_in_ready): each word is either a load, which
// writes one keyframe entry, or a tick, which while playing advances the
// playhead by delta_time times tick_rate, wraps it by loop_length and
// produces one interpolated pose word on the output channel
// (o_out_valid / i_out_ready). Loads and ticks that produce nothing give no
// output word. Configuration words arrive on i_cfg_valid / o_cfg_ready and
// must only be written while the block is idle.
// A word passes through the front register and is popped from the queue by
// the back end. A tick advances the playhead, wraps it by a bit-serial modulo
// if needed, scans keyframes through the table's single read port, runs the
// bit-serial factor division and the seven interpolations, and emits the
// pose. A load retires when the back end pops it.
// Reset clears the playhead, the configuration and all handshake state; the
// keyframe table is not cleared. When the receiver stalls the result waits
// in the output register, and the front keeps queueing words until the
// two-entry queue is full.
module keyframe_pose_sampler #(
    parameter int MAX_FRAMES = kps_pkg::MAX_FRAMES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [3:0]                     i_key_index,
    input  logic [31:0]                    i_key_time,
    input  logic signed [31:0]             i_key_pos_x,
    input  logic signed [31:0]             i_key_pos_y,
    input  logic signed [31:0]             i_key_pos_z,
    input  logic signed [31:0]             i_key_pitch,
    input  logic signed [31:0]             i_key_scale_x,
    input  logic signed [31:0]             i_key_scale_y,
    input  logic signed [31:0]             i_key_scale_z,
    input  logic [23:0]                    i_delta_time,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic signed [31:0]             o_out_pos_x,
    output logic signed [31:0]             o_out_pos_y,
    output logic signed [31:0]             o_out_pos_z,
    output logic signed [31:0]             o_out_pitch,
    output logic signed [31:0]             o_out_scale_x,
    output logic signed [31:0]             o_out_scale_y,
    output logic signed [31:0]             o_out_scale_z,
    output logic [31:0]                    o_anim_time,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import kps_pkg::*;

    t_cfg  r_cfg;
    t_item in_item;
    t_item fq_item;
    t_item qb_item;
    t_pose pose;
    logic  fq_push;
    logic  fq_ready;
    logic  qb_valid;
    logic  qb_pop;

    // Configuration writes are always taken; unknown indices are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.playing     <= 1'b0;
            r_cfg.tick_rate   <= 32'h0001_0000;
            r_cfg.loop_length <= 32'h0001_0000;
            r_cfg.frame_count <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PLAYING:     r_cfg.playing     <= i_cfg_data[0];
                CFG_TICK_RATE:   r_cfg.tick_rate   <= i_cfg_data;
                CFG_LOOP_LENGTH: r_cfg.loop_length <= i_cfg_data;
                CFG_FRAME_COUNT: r_cfg.frame_count <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Pack the payload ports into one word; value order matches the pose word.
    always_comb begin
        in_item.is_tick        = i_req_type;
        in_item.key_index      = i_key_index;
        in_item.entry.key_time = i_key_time;
        in_item.entry.vals[0]  = i_key_pos_x;
        in_item.entry.vals[1]  = i_key_pos_y;
        in_item.entry.vals[2]  = i_key_pos_z;
        in_item.entry.vals[3]  = i_key_pitch;
        in_item.entry.vals[4]  = i_key_scale_x;
        in_item.entry.vals[5]  = i_key_scale_y;
        in_item.entry.vals[6]  = i_key_scale_z;
        in_item.delta          = i_delta_time;
    end

    kps_front #(.MAX_FRAMES(MAX_FRAMES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_item       (in_item),
        .o_push       (fq_push),
        .i_push_ready (fq_ready),
        .o_item       (fq_item)
    );

    kps_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (fq_push),
        .o_push_ready (fq_ready),
        .i_item       (fq_item),
        .o_valid      (qb_valid),
        .i_pop        (qb_pop),
        .o_item       (qb_item)
    );

    kps_back #(.MAX_FRAMES(MAX_FRAMES)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (qb_valid),
        .o_pop   (qb_pop),
        .i_item  (qb_item),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pose  (pose)
    );

    assign o_out_pos_x   = pose.vals[0];
    assign o_out_pos_y   = pose.vals[1];
    assign o_out_pos_z   = pose.vals[2];
    assign o_out_pitch   = pose.vals[3];
    assign o_out_scale_x = pose.vals[4];
    assign o_out_scale_y = pose.vals[5];
    assign o_out_scale_z = pose.vals[6];
    assign o_anim_time   = pose.anim_time;

endmodule

// ----- sim/kps_checker.sv -----
module kps_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               o_in_ready,
    input  logic               i_req_type,
    input  logic [3:0]         i_key_index,
    input  logic [31:0]        i_key_time,
    input  logic signed [31:0] i_key_pos_x,
    input  logic signed [31:0] i_key_pos_y,
    input  logic signed [31:0] i_key_pos_z,
    input  logic signed [31:0] i_key_pitch,
    input  logic signed [31:0] i_key_scale_x,
    input  logic signed [31:0] i_key_scale_y,
    input  logic signed [31:0] i_key_scale_z,
    input  logic [23:0]        i_delta_time,
    input  logic               o_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] o_out_pos_x,
    input  logic signed [31:0] o_out_pos_y,
    input  logic signed [31:0] o_out_pos_z,
    input  logic signed [31:0] o_out_pitch,
    input  logic signed [31:0] o_out_scale_x,
    input  logic signed [31:0] o_out_scale_y,
    input  logic signed [31:0] o_out_scale_z,
    input  logic [31:0]        o_anim_time,
    input  logic               i_cfg_valid,
    input  logic               o_cfg_ready,
    input  logic [kps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_poses
);
    timeunit 1ns;
    timeprecision 1ps;
    import kps_pkg::*;

    localparam int FRAMES = MAX_FRAMES_DEF;

    logic              play_on;
    logic [31:0]       rate_q16;
    logic [31:0]       loop_len;
    logic [4:0]        frames_used;
    logic [31:0]       playhead;
    logic [31:0]       key_times [FRAMES];
    logic [31:0]       key_vals  [FRAMES][NUM_VALS];
    t_pose             poses_due [$];

    string val_names [NUM_VALS] = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_pitch",
                                    "out_scale_x", "out_scale_y", "out_scale_z"};

    assign o_pending = poses_due.size();

    // Advances the playhead for one tick and queues the pose it yields, if any.
    task automatic advance_and_sample(input logic [23:0] dt);
        logic [63:0]        sum;
        logic [31:0]        t0, t1;
        logic [15:0]        factor;
        logic signed [63:0] a, b, prod;
        logic [63:0]        quot;
        int                 n;
        bit                 hit;
        t_pose              p;
        sum = 64'(playhead) + ((64'(dt) * 64'(rate_q16)) >> 16);
        playhead = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        if (loop_len != 0 && playhead > loop_len)
            playhead = playhead % loop_len;
        n = (frames_used > FRAMES) ? FRAMES : int'(frames_used);
        hit = 0;
        for (int i = 0; i + 1 < n && !hit; i++) begin
            t0 = key_times[i];
            t1 = key_times[i + 1];
            if (playhead >= t0 && playhead < t1) begin
                hit = 1;
                quot = (64'(playhead - t0) << 16) / 64'(t1 - t0);
                factor = quot[15:0];
                for (int j = 0; j < NUM_VALS; j++) begin
                    a = $signed({{32{key_vals[i][j][31]}}, key_vals[i][j]});
                    b = $signed({{32{key_vals[i + 1][j][31]}}, key_vals[i + 1][j]});
                    // Arithmetic shift of the product is the floor the format asks for.
                    prod = (b - a) * $signed({48'd0, factor});
                    p.vals[j] = 32'(a + (prod >>> 16));
                end
                p.anim_time = playhead;
                poses_due.push_back(p);
            end
        end
    endtask

    task automatic compare_pose(input t_pose p);
        logic [31:0] got [NUM_VALS];
        got = '{o_out_pos_x, o_out_pos_y, o_out_pos_z, o_out_pitch,
                o_out_scale_x, o_out_scale_y, o_out_scale_z};
        for (int j = 0; j < NUM_VALS; j++)
            if (got[j] !== p.vals[j]) begin
                $error("%s: expected %h, got %h", val_names[j], p.vals[j], got[j]);
                o_errors++;
            end
        if (o_anim_time !== p.anim_time) begin
            $error("anim_time: expected %h, got %h", p.anim_time, o_anim_time);
            o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_poses  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            play_on     = 1'b0;
            rate_q16    = 32'h0001_0000;
            loop_len    = 32'h0001_0000;
            frames_used = '0;
            playhead    = '0;
            poses_due.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PLAYING:     play_on     = i_cfg_data[0];
                    CFG_TICK_RATE:   rate_q16    = i_cfg_data;
                    CFG_LOOP_LENGTH: loop_len    = i_cfg_data;
                    CFG_FRAME_COUNT: frames_used = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                if (i_req_type == REQ_LOAD) begin
                    key_times[i_key_index] = i_key_time;
                    key_vals[i_key_index] = '{i_key_pos_x, i_key_pos_y, i_key_pos_z,
                                              i_key_pitch, i_key_scale_x, i_key_scale_y,
                                              i_key_scale_z};
                end else if (play_on) begin
                    advance_and_sample(i_delta_time);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (poses_due.size() == 0) begin
                    $error("pose word with none expected: anim_time %h", o_anim_time);
                    o_errors++;
                end else begin
                    compare_pose(poses_due.pop_front());
                    o_poses++;
                end
            end
        end
    end
endmodule

// ----- sim/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kps_pkg::*;

    // A generous ceiling: roughly a thousand words, stretched by random gaps,
    // stalls, idle settling and the long hold-off.
    localparam int LIMIT_CYCLES = 1_500_000;
    // Settling time after the last pose word, covering a tick that yields nothing.
    localparam int SETTLE_CYCLES = 300;
    // An index past the last register, which the block must ignore.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd5;
    localparam int FRAMES = MAX_FRAMES_DEF;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_req_type = REQ_LOAD;
    logic [3:0]         i_key_index = '0;
    logic [31:0]        i_key_time = '0;
    logic signed [31:0] i_key_pos_x = '0;
    logic signed [31:0] i_key_pos_y = '0;
    logic signed [31:0] i_key_pos_z = '0;
    logic signed [31:0] i_key_pitch = '0;
    logic signed [31:0] i_key_scale_x = '0;
    logic signed [31:0] i_key_scale_y = '0;
    logic signed [31:0] i_key_scale_z = '0;
    logic [23:0]        i_delta_time = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_out_pos_x, o_out_pos_y, o_out_pos_z, o_out_pitch;
    logic signed [31:0] o_out_scale_x, o_out_scale_y, o_out_scale_z;
    logic [31:0]        o_anim_time;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]        i_cfg_data = '0;

    int o_errors, o_pending, o_poses;

    // Percentages of cycles in which the sender leaves a gap and the receiver stalls.
    int gap_pct   = 0;
    int stall_pct = 0;
    // While nonzero the receiver refuses every pose word, one cycle per count.
    int hold_left = 0;
    int words_sent = 0;

    keyframe_pose_sampler dut (.*);
    kps_checker checker_i (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // The receiver: random stalls, with a long hold-off on request so that the
    // output register and the queue fill and the input channel backs up.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d pose words still due", LIMIT_CYCLES, o_pending);
        $display("testbench: errors");
        $finish;
    end

    function automatic logic [NUM_VALS-1:0][31:0] random_vals();
        logic [NUM_VALS-1:0][31:0] v;
        for (int j = 0; j < NUM_VALS; j++)
            v[j] = $urandom;
        return v;
    endfunction

    // Offers one word and holds it until it is taken, then perhaps leaves a gap.
    // Valid is only lowered when a gap follows, so it never drops and rises in
    // the same step.
    task automatic offer_word(input logic kind, input logic [3:0] idx, input logic [31:0] t,
                              input logic [NUM_VALS-1:0][31:0] v, input logic [23:0] dt);
        i_in_valid    <= 1'b1;
        i_req_type    <= kind;
        i_key_index   <= idx;
        i_key_time    <= t;
        i_key_pos_x   <= v[0];
        i_key_pos_y   <= v[1];
        i_key_pos_z   <= v[2];
        i_key_pitch   <= v[3];
        i_key_scale_x <= v[4];
        i_key_scale_y <= v[5];
        i_key_scale_z <= v[6];
        i_delta_time  <= dt;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
    endtask

    task automatic load_key(input logic [3:0] idx, input logic [31:0] t,
                            input logic [NUM_VALS-1:0][31:0] v);
        offer_word(REQ_LOAD, idx, t, v, 24'($urandom));
    endtask

    // The key fields of a tick are ignored, so they carry random noise.
    task automatic tick(input logic [23:0] dt);
        offer_word(REQ_TICK, 4'($urandom), $urandom, random_vals(), dt);
    endtask

    // Stops offering, waits for every pose word due and lets a tick that yields
    // nothing drain before the registers may be touched.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (o_pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic close_cfg();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic play, input logic [31:0] rate,
                             input logic [31:0] len, input logic [4:0] n);
        settle();
        write_reg(CFG_PLAYING, {31'd0, play});
        write_reg(CFG_TICK_RATE, rate);
        write_reg(CFG_LOOP_LENGTH, len);
        write_reg(CFG_FRAME_COUNT, {27'd0, n});
        close_cfg();
    endtask

    initial begin
        logic [NUM_VALS-1:0][31:0] vals;
        logic [31:0] span, step, rate, len, t;
        logic [63:0] adv, dt;
        logic [4:0]  nframes;
        int          pick;

        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        @(posedge i_clk);

        // Directed part. The whole table is written first, so no later tick can
        // read an entry that was never loaded. Entry 0 holds the most negative
        // value and entry 1 the most positive, which exercises the widest lerp.
        for (int i = 0; i < FRAMES; i++) begin
            if (i == 0)
                vals = {NUM_VALS{32'h8000_0000}};
            else if (i == 1)
                vals = {NUM_VALS{32'h7FFF_FFFF}};
            else
                vals = random_vals();
            load_key(4'(i), 32'(i) * 32'h1000, vals);
        end
        // Still stopped after reset: the tick must change nothing.
        tick(24'h00_8000);

        configure(1'b1, 32'h0001_0000, 32'h0001_0000, 5'd16);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        close_cfg();
        tick(24'h00_0000);          // playhead at zero: factor zero
        tick(24'h00_0800);          // halfway through the widest interval
        tick(24'h00_0FFF);
        tick(24'hFF_FFFF);          // overshoots the loop and wraps

        configure(1'b1, 32'h0001_0000, 32'h0001_0000, 5'd1);
        tick(24'h00_0100);          // fewer than two frames in use
        configure(1'b1, 32'h0001_0000, 32'h0001_0000, 5'd31);
        tick(24'h00_0100);          // count above the table size acts as full
        configure(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 5'd16);
        tick(24'hFF_FFFF);          // saturates, no wrap, no interval matches
        configure(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 5'd0);
        tick(24'hFF_FFFF);          // zero rate, no frames in use

        // Random phases, each with its own idling style and settings. Most of
        // the words form a well-ordered table followed by ticks that walk the
        // playhead through it; stray loads and odd settings are the noise.
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 11; stall_pct = 11; end
            endcase

            pick = $urandom_range(9);
            if (pick < 5)
                span = $urandom_range(32'h100, 32'hFFFF);
            else if (pick < 9)
                span = $urandom_range(32'h1_0000, 32'hFF_FFFF);
            else
                span = 32'hFFFF_F000;
            step = span / FRAMES;

            pick = $urandom_range(9);
            if (pick < 6)
                rate = 32'h0001_0000;
            else if (pick < 9)
                rate = $urandom_range(32'h8000, 32'h4_0000);
            else
                rate = $urandom;
            len = ($urandom_range(5) == 0) ? 32'h0 : span;
            pick = $urandom_range(9);
            if (pick < 7)
                nframes = 5'($urandom_range(2, FRAMES));
            else if (pick < 8)
                nframes = 5'($urandom_range(0, 1));
            else
                nframes = 5'($urandom_range(FRAMES + 1, 31));

            configure(ph != 5, rate, len, nframes);

            for (int i = 0; i < FRAMES; i++) begin
                t = 32'(i) * step + 32'($urandom_range(0, step / 2));
                load_key(4'(i), t, random_vals());
            end

            for (int k = 0; k < 70; k++) begin
                if (ph == 2 && k == 10)
                    hold_left = 600;
                if ($urandom_range(14) == 0) begin
                    load_key(4'($urandom), $urandom_range(0, span), random_vals());
                end else begin
                    adv = 64'($urandom_range(0, step));
                    dt = (rate == 0) ? 64'($urandom) : (adv << 16) / 64'(rate);
                    if ($urandom_range(19) == 0)
                        dt = 64'($urandom);
                    tick((dt > 64'hFF_FFFF) ? 24'hFF_FFFF : dt[23:0]);
                end
            end
        end

        settle();
        $display("summary: %0d words offered, %0d pose words checked,", words_sent, o_poses);
        $display("summary: 12 random phases with gaps, stalls and a long output hold-off");
        if (o_errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
